>>> hdl/wrusv_pkg.sv
// Shared types, codes and helpers for the win-ratio U-statistic variance unit.
// No dependencies; imported by the top-level module.
`default_nettype none

package wrusv_pkg;

	localparam int COUNT_W = 7;
	localparam int INDEX_W = 6;
	localparam int CFG_INDEX_W = 2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TREAT_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_TIES    = 2'd2;

	// Item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	// Pair outcome codes
	localparam logic [1:0] OUT_CTRL_WIN  = 2'd0;
	localparam logic [1:0] OUT_TIE       = 2'd1;
	localparam logic [1:0] OUT_TREAT_WIN = 2'd2;
	localparam logic [1:0] OUT_NONE      = 2'd3;

	// Statistic indexes
	localparam logic [2:0] STAT_NT      = 3'd0;
	localparam logic [2:0] STAT_NC      = 3'd1;
	localparam logic [2:0] STAT_ST      = 3'd2;
	localparam logic [2:0] STAT_COVNULL = 3'd7;

	// Operand pairs of the six triple sums
	localparam int PAIR_A [6] = '{0, 1, 0, 2, 3, 2};
	localparam int PAIR_B [6] = '{0, 1, 1, 2, 3, 3};

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] treat_index;
		logic [INDEX_W-1:0] control_index;
		logic [1:0]         outcome;
	} item_t;

	typedef struct packed {
		logic [2:0]         stat_index;
		logic signed [63:0] stat_value;
		logic               last;
	} result_t;

	// Doubled kernel values {k2, l2} of one outcome code
	function automatic logic [3:0] kernel_f(input logic [1:0] code, input logic split);
		logic [3:0] kl;
		kl = 4'd0;
		unique case (code)
			OUT_CTRL_WIN:  kl = {2'd0, 2'd2};
			OUT_TREAT_WIN: kl = {2'd2, 2'd0};
			OUT_TIE:       kl = split ? {2'd1, 2'd1} : 4'd0;
			default:       kl = 4'd0;
		endcase
		return kl;
	endfunction

endpackage

`default_nettype wire

>>> hdl/win_ratio_u_statistic_variance_unit.sv
// Win-ratio U-statistic variance unit: outcome matrix store, sequencer and datapath.
// Depends on wrusv_pkg (types, codes, kernel helper).
//
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------
// item      | in        | start high while busy low  | item_t: kind, indexes, outcome
// result    | out       | result_strobe, one cycle   | result_t: stat_index, value, last
// config    | in        | cfg_we, taken at once      | cfg_index, cfg_data
//
// A load item leaves busy low, so loads can stream every cycle.
// A compute item walks the store through its single read port: a count pass, then the
// row and column passes, then per variance term a bit-serial multiply and divide.
// The eight results leave during the compute, one strobe each; the receiver cannot stall.
// Reset clears control state only; the matrix store has no clearing pass.
`default_nettype none

module win_ratio_u_statistic_variance_unit
	import wrusv_pkg::*;
#(
	parameter int MAX_TREAT   = 64,
	parameter int MAX_CONTROL = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  item_t                   item,
	output logic                    result_strobe,
	output result_t                 result,
	input  wire                     cfg_we,
	input  wire [CFG_INDEX_W-1:0]   cfg_index,
	input  wire [COUNT_W-1:0]       cfg_data
);

	// Widths follow from the matrix size
	localparam int MEM_DEPTH = MAX_TREAT * MAX_CONTROL;
	localparam int AW   = $clog2(MEM_DEPTH);
	localparam int TIW  = $clog2(MAX_TREAT);
	localparam int CIW  = $clog2(MAX_CONTROL);
	localparam int NTW  = $clog2(MAX_TREAT + 1);
	localparam int NCW  = $clog2(MAX_CONTROL + 1);
	localparam int MAXD = (MAX_TREAT > MAX_CONTROL) ? MAX_TREAT : MAX_CONTROL;
	localparam int LW   = $clog2(MAXD + 1);
	localparam int PW   = $clog2(MEM_DEPTH + 1);  // Nt*Nc
	localparam int HW   = PW + 1;                 // win counts in halves
	localparam int XW   = PW + 4;                 // centered kernel terms
	localparam int SW   = XW + LW;                // line sums
	localparam int DW   = 2 * XW + LW;            // line sums of products
	localparam int PPW  = 2 * SW;
	localparam int TW   = PPW + LW + 1;           // triple sums
	localparam int FW   = PW;                     // front factors
	localparam int NW   = TW + FW + 2;            // numerator
	localparam int DENW = 3 * PW + 4;
	localparam int RW   = DENW + 1;
	localparam int DDW  = NW + 32;                // dividend, scaled by 2^32
	localparam int QW   = DDW + 1;
	localparam int SATW = (QW > 65) ? QW : 65;
	localparam int BCW  = $clog2(DDW);
	localparam logic [2:0] K_LAST = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LINE, ST_DRAIN, ST_FIN_MUL, ST_FIN_ADD, ST_EMIT_NT, ST_EMIT_NC,
		ST_SETUP_A, ST_SETUP_B, ST_SETUP_C, ST_MUL, ST_NEG, ST_DIV, ST_ROUND,
		ST_EMIT_VAR, ST_EMIT_ZERO
	} state_t;

	typedef enum logic [1:0] {M_CNT, M_P1, M_P2} mode_t;

	state_t state_q;
	mode_t  mode_q;

	// Configuration registers
	logic [COUNT_W-1:0] treat_count_q, control_count_q;
	logic               split_ties_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			treat_count_q   <= COUNT_W'(1);
			control_count_q <= COUNT_W'(1);
			split_ties_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TREAT_COUNT:   treat_count_q   <= cfg_data;
				REG_CONTROL_COUNT: control_count_q <= cfg_data;
				REG_SPLIT_TIES:    split_ties_q    <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Clamp counts into 1..MAX
	logic [31:0]    tc32, cc32;
	logic [NTW-1:0] nt_w;
	logic [NCW-1:0] nc_w;
	assign tc32 = 32'(treat_count_q);
	assign cc32 = 32'(control_count_q);
	assign nt_w = NTW'((tc32 == 32'd0) ? 32'd1 :
		((tc32 > 32'(MAX_TREAT)) ? 32'(MAX_TREAT) : tc32));
	assign nc_w = NCW'((cc32 == 32'd0) ? 32'd1 :
		((cc32 > 32'(MAX_CONTROL)) ? 32'(MAX_CONTROL) : cc32));

	logic accept, go_load, go_compute;
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign go_load    = accept && (item.kind == KIND_LOAD);
	assign go_compute = accept && (item.kind == KIND_COMPUTE);

	// Walk counters
	logic [TIW-1:0] ti_q;
	logic [CIW-1:0] cj_q;
	logic [2:0]     k_q;
	logic [BCW-1:0] bc_q;
	logic [NTW-1:0] nt_q, nt_m1;
	logic [NCW-1:0] nc_q, nc_m1;
	logic row_last, col_last, inner_last, outer_last, var_en;

	assign nt_m1      = NTW'(nt_q - 1'b1);
	assign nc_m1      = NCW'(nc_q - 1'b1);
	assign row_last   = (NTW'(ti_q) == nt_m1);
	assign col_last   = (NCW'(cj_q) == nc_m1);
	assign inner_last = (mode_q == M_P2) ? row_last : col_last;
	assign outer_last = (mode_q == M_P2) ? col_last : row_last;
	assign var_en     = (nt_q > NTW'(1)) && (nc_q > NCW'(1));

	// Outcome store: one write port for loads, one registered read port for the walk
	logic [1:0]    mem [MEM_DEPTH];
	logic [1:0]    rdata_s1;
	logic [AW-1:0] rd_addr, ld_addr;
	logic [31:0]   ld_addr_w;
	logic          ld_ok;

	assign ld_addr_w = 32'(item.treat_index) * 32'(MAX_CONTROL) + 32'(item.control_index);
	assign ld_addr   = AW'(ld_addr_w);
	assign ld_ok     = (32'(item.treat_index) < 32'(MAX_TREAT)) &&
		(32'(item.control_index) < 32'(MAX_CONTROL));
	assign rd_addr   = AW'(AW'(ti_q) * AW'(MAX_CONTROL)) + AW'(cj_q);

	always_ff @(posedge clk) begin
		if (go_load && ld_ok) begin
			mem[ld_addr] <= item.outcome;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Element pipeline valids
	logic v_s1, v_s2, v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_LINE);
			v_s2 <= v_s1 && (mode_q != M_CNT);
			v_s3 <= v_s2;
		end
	end

	// Datapath registers
	logic [HW-1:0]            hk_q, hl_q, twop_q;
	logic [PW-1:0]            prod_q, fa_q, fb_q, m_q, fa_sh_q, fb_sh_q;
	logic [2*PW-1:0]          psq_q;
	logic [DENW-1:0]          den_q;
	logic signed [XW-1:0]     ck_q, cl_q, c0_q;
	logic signed [XW-1:0]     x_s2 [4];
	logic signed [2*XW-1:0]   pr_s3 [6];
	logic signed [SW-1:0]     s_q [4];
	logic signed [DW-1:0]     diag_q [6];
	logic signed [PPW-1:0]    pp_q [6];
	logic signed [TW-1:0]     tri1_q [6], tri2_q [6];
	logic signed [NW-1:0]     acc_q, add1, add2;
	logic [DDW-1:0]           dq_q;
	logic [RW-1:0]            r_q, r_sh;
	logic [QW-1:0]            qr_q;
	logic                     neg_q, qb;
	logic [3:0]               kl;
	logic [HW:0]              selk, sell;
	logic signed [XW-1:0]     x_w [4];
	logic                     clr_line, mul_init;

	assign kl   = kernel_f(rdata_s1, split_ties_q);
	assign selk = (kl[3:2] == 2'd2) ? {twop_q, 1'b0} :
		((kl[3:2] == 2'd1) ? {1'b0, twop_q} : '0);
	assign sell = (kl[1:0] == 2'd2) ? {twop_q, 1'b0} :
		((kl[1:0] == 2'd1) ? {1'b0, twop_q} : '0);
	assign x_w[0] = $signed(XW'(selk)) - ck_q;
	assign x_w[1] = $signed(XW'(sell)) - cl_q;
	assign x_w[2] = $signed(XW'(selk)) - c0_q;
	assign x_w[3] = $signed(XW'(sell)) - c0_q;

	assign clr_line = (state_q == ST_SETUP_C) || (state_q == ST_FIN_ADD);
	assign mul_init = ((state_q == ST_FIN_ADD) && outer_last && (mode_q == M_P2)) ||
		((state_q == ST_EMIT_VAR) && (k_q != K_LAST));

	assign add1 = fa_sh_q[FW-1] ? NW'(tri1_q[0]) : {NW{1'b0}};
	assign add2 = fb_sh_q[FW-1] ? NW'(tri2_q[0]) : {NW{1'b0}};
	assign r_sh = {r_q[RW-2:0], dq_q[DDW-1]};
	assign qb   = (r_sh >= RW'(den_q));

	always_ff @(posedge clk) begin
		if (go_compute) begin
			nt_q <= nt_w;
			nc_q <= nc_w;
			hk_q <= '0;
			hl_q <= '0;
		end
		// Count pass: sum the doubled kernels
		if (v_s1 && (mode_q == M_CNT)) begin
			hk_q <= hk_q + HW'(kl[3:2]);
			hl_q <= hl_q + HW'(kl[1:0]);
		end
		// Center the kernels, then multiply, then accumulate per line
		for (int p = 0; p < 4; p++) begin
			x_s2[p] <= x_w[p];
		end
		for (int p = 0; p < 6; p++) begin
			pr_s3[p] <= (2*XW)'(x_s2[PAIR_A[p]]) * (2*XW)'(x_s2[PAIR_B[p]]);
		end
		for (int p = 0; p < 4; p++) begin
			if (clr_line) s_q[p] <= '0;
			else if (v_s2) s_q[p] <= s_q[p] + SW'(x_s2[p]);
		end
		for (int p = 0; p < 6; p++) begin
			if (clr_line) diag_q[p] <= '0;
			else if (v_s3) diag_q[p] <= diag_q[p] + DW'(pr_s3[p]);
		end
		unique case (state_q)
			ST_SETUP_A: begin
				prod_q <= PW'(PW'(nt_q) * PW'(nc_q));
				fa_q   <= PW'(PW'(nc_q) * PW'(nt_m1));
				fb_q   <= PW'(PW'(nt_q) * PW'(nc_m1));
				m_q    <= PW'(PW'(nt_m1) * PW'(nc_m1));
				ck_q   <= $signed(XW'({hk_q, 1'b0}));
				cl_q   <= $signed(XW'({hl_q, 1'b0}));
				c0_q   <= $signed(XW'(hk_q) + XW'(hl_q));
			end
			ST_SETUP_B: begin
				psq_q  <= (2*PW)'(prod_q) * (2*PW)'(prod_q);
				twop_q <= {prod_q, 1'b0};
			end
			ST_SETUP_C: begin
				den_q <= DENW'({DENW'(psq_q) * DENW'(m_q), 4'b0000});
				for (int p = 0; p < 6; p++) begin
					tri1_q[p] <= '0;
					tri2_q[p] <= '0;
				end
			end
			ST_FIN_MUL: begin
				for (int p = 0; p < 6; p++) begin
					pp_q[p] <= PPW'(s_q[PAIR_A[p]]) * PPW'(s_q[PAIR_B[p]]);
				end
			end
			ST_FIN_ADD: begin
				for (int p = 0; p < 6; p++) begin
					if (mode_q == M_P1) tri1_q[p] <= tri1_q[p] + TW'(pp_q[p]) - TW'(diag_q[p]);
					else tri2_q[p] <= tri2_q[p] + TW'(pp_q[p]) - TW'(diag_q[p]);
				end
			end
			ST_MUL: begin
				// Shift-add: numerator = T1*fa + T2*fb, MSB first
				acc_q   <= (acc_q <<< 1) + add1 + add2;
				fa_sh_q <= {fa_sh_q[FW-2:0], 1'b0};
				fb_sh_q <= {fb_sh_q[FW-2:0], 1'b0};
			end
			ST_NEG: begin
				neg_q <= acc_q[NW-1];
				dq_q  <= {NW'(acc_q[NW-1] ? -acc_q : acc_q), 32'd0};
				r_q   <= '0;
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle
				r_q  <= qb ? RW'(r_sh - RW'(den_q)) : r_sh;
				dq_q <= {dq_q[DDW-2:0], qb};
			end
			ST_ROUND: begin
				qr_q <= QW'(dq_q) + QW'(r_q >= (RW'(den_q) - r_q));
			end
			ST_EMIT_VAR: begin
				// Bring the next pair of triple sums to the front
				for (int p = 0; p < 6; p++) begin
					tri1_q[p] <= tri1_q[(p + 1) % 6];
					tri2_q[p] <= tri2_q[(p + 1) % 6];
				end
			end
			default: ;
		endcase
		if (mul_init) begin
			acc_q   <= '0;
			fa_sh_q <= fa_q;
			fb_sh_q <= fb_q;
		end
	end

	// Saturate to signed Q32.32 and restore the sign
	logic [SATW-1:0] q_x, q_lim, q_mag;
	logic [63:0]     var_val;
	assign q_x     = SATW'(qr_q);
	assign q_lim   = neg_q ? SATW'(64'h8000_0000_0000_0000) : SATW'(64'h7FFF_FFFF_FFFF_FFFF);
	assign q_mag   = (q_x > q_lim) ? q_lim : q_x;
	assign var_val = neg_q ? (~q_mag[63:0] + 64'd1) : q_mag[63:0];

	// Sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= M_CNT;
			ti_q          <= '0;
			cj_q          <= '0;
			k_q           <= '0;
			bc_q          <= '0;
			result_strobe <= 1'b0;
			result        <= '0;
		end else begin
			result_strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (go_compute) begin
						mode_q  <= M_CNT;
						ti_q    <= '0;
						cj_q    <= '0;
						state_q <= ST_LINE;
					end
				end
				ST_LINE: begin
					// Issue one read, advance along the line
					if (inner_last) begin
						if (mode_q == M_P2) ti_q <= '0;
						else cj_q <= '0;
						state_q <= ST_DRAIN;
					end else if (mode_q == M_P2) begin
						ti_q <= ti_q + 1'b1;
					end else begin
						cj_q <= cj_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						if (mode_q != M_CNT) begin
							state_q <= ST_FIN_MUL;
						end else if (row_last) begin
							ti_q    <= '0;
							state_q <= ST_EMIT_NT;
						end else begin
							ti_q    <= ti_q + 1'b1;
							state_q <= ST_LINE;
						end
					end
				end
				ST_FIN_MUL: state_q <= ST_FIN_ADD;
				ST_FIN_ADD: begin
					if (!outer_last) begin
						if (mode_q == M_P2) cj_q <= cj_q + 1'b1;
						else ti_q <= ti_q + 1'b1;
						state_q <= ST_LINE;
					end else if (mode_q == M_P1) begin
						mode_q  <= M_P2;
						ti_q    <= '0;
						cj_q    <= '0;
						state_q <= ST_LINE;
					end else begin
						k_q     <= '0;
						bc_q    <= BCW'(FW - 1);
						state_q <= ST_MUL;
					end
				end
				ST_EMIT_NT: begin
					result_strobe     <= 1'b1;
					result.stat_index <= STAT_NT;
					result.stat_value <= 64'(hk_q) << 31;
					result.last       <= 1'b0;
					state_q           <= ST_EMIT_NC;
				end
				ST_EMIT_NC: begin
					result_strobe     <= 1'b1;
					result.stat_index <= STAT_NC;
					result.stat_value <= 64'(hl_q) << 31;
					result.last       <= 1'b0;
					k_q               <= '0;
					state_q           <= var_en ? ST_SETUP_A : ST_EMIT_ZERO;
				end
				ST_SETUP_A: state_q <= ST_SETUP_B;
				ST_SETUP_B: state_q <= ST_SETUP_C;
				ST_SETUP_C: begin
					mode_q  <= M_P1;
					ti_q    <= '0;
					cj_q    <= '0;
					state_q <= ST_LINE;
				end
				ST_MUL: begin
					if (bc_q == '0) state_q <= ST_NEG;
					else bc_q <= bc_q - 1'b1;
				end
				ST_NEG: begin
					bc_q    <= BCW'(DDW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bc_q == '0) state_q <= ST_ROUND;
					else bc_q <= bc_q - 1'b1;
				end
				ST_ROUND: state_q <= ST_EMIT_VAR;
				ST_EMIT_VAR: begin
					result_strobe     <= 1'b1;
					result.stat_index <= STAT_ST + k_q;
					result.stat_value <= var_val;
					result.last       <= (k_q == K_LAST);
					if (k_q == K_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						bc_q    <= BCW'(FW - 1);
						state_q <= ST_MUL;
					end
				end
				ST_EMIT_ZERO: begin
					// Too few subjects: all variance terms are zero
					result_strobe     <= 1'b1;
					result.stat_index <= STAT_ST + k_q;
					result.stat_value <= '0;
					result.last       <= (k_q == K_LAST);
					if (k_q == K_LAST) state_q <= ST_IDLE;
					else k_q <= k_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The final flag marks only the last statistic
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> result.stat_index == STAT_COVNULL)
		else $error("last flag on wrong statistic");

	// The nc count follows the nt count in the next cycle
	a_nc_after_nt: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.stat_index == STAT_NC) |-> $past(result_strobe))
		else $error("nc not right after nt");

	// Line sums are only used once the element pipeline is empty
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_MUL) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("line finished before pipeline drained");

	// A load never occupies the block; a compute always does
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		go_load |=> !busy)
		else $error("load item left block busy");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go_compute |=> busy)
		else $error("compute item did not start");

endmodule

`default_nettype wire

>>> tb/sv/win_ratio_u_statistic_variance_unit_tb.sv
// Self-checking testbench for win_ratio_u_statistic_variance_unit.
// Depends on wrusv_pkg and the unit RTL; predicts all eight statistics per compute item.
`timescale 1ns / 1ps

module win_ratio_u_statistic_variance_unit_tb;
	import wrusv_pkg::*;

	localparam int MAXT = 64;
	localparam int MAXC = 64;
	localparam int RANDOM_ITEMS = 410;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	item_t                  item;
	logic                   result_strobe;
	result_t                result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [COUNT_W-1:0]     cfg_data;

	win_ratio_u_statistic_variance_unit #(
		.MAX_TREAT(MAXT),
		.MAX_CONTROL(MAXC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Items waiting to be driven, statistics waiting to be seen.
	item_t   pending_items[$];
	result_t expected_stats[$];
	int      errors;

	// Predictor state: matrix copy and register copy.
	logic [1:0]         matrix_copy[MAXT*MAXC];
	logic [COUNT_W-1:0] treat_reg, control_reg;
	logic               split_reg;

	// Generator bookkeeping: which matrix cells have been loaded so far.
	bit cell_loaded[MAXT*MAXC];
	int random_count;

	// Pair operands of the six triple sums.
	int pair_lo[6] = '{0, 1, 0, 2, 3, 2};
	int pair_hi[6] = '{0, 1, 1, 2, 3, 3};

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int clamp_count(input logic [COUNT_W-1:0] v, input int max);
		if (v < 1)
			return 1;
		return (v > max) ? max : int'(v);
	endfunction

	// Doubled kernel values of one outcome code under the current tie rule.
	function automatic void doubled_kernel(input logic [1:0] code, output int k2, output int l2);
		k2 = 0;
		l2 = 0;
		if (code == OUT_CTRL_WIN)
			l2 = 2;
		else if (code == OUT_TREAT_WIN)
			k2 = 2;
		else if (code == OUT_TIE && split_reg) begin
			k2 = 1;
			l2 = 1;
		end
	endfunction

	// Work out the eight statistics of a compute item and queue them.
	task automatic predict_stats();
		int nt, nc, i, t, p, k, part, outer, inner, addr, k2, l2, half_k, half_l;
		logic signed [127:0] ts[12];
		logic signed [127:0] s[4];
		logic signed [127:0] dg[6];
		logic signed [127:0] x[4];
		logic signed [127:0] twop, ck, cl, c0, num;
		logic [191:0] mag, q, r, den, lim;
		logic [63:0] vals[8];
		bit neg;
		result_t rs;
		nt = clamp_count(treat_reg, MAXT);
		nc = clamp_count(control_reg, MAXC);
		half_k = 0;
		half_l = 0;
		for (i = 0; i < nt; i++)
			for (t = 0; t < nc; t++) begin
				doubled_kernel(matrix_copy[i*MAXC+t], k2, l2);
				half_k += k2;
				half_l += l2;
			end
		vals[0] = 64'(half_k) << 31;
		vals[1] = 64'(half_l) << 31;
		for (k = 2; k < 8; k++)
			vals[k] = '0;
		if (nt > 1 && nc > 1) begin
			twop = 2 * nt * nc;
			ck = 2 * half_k;
			cl = 2 * half_l;
			c0 = half_k + half_l;
			for (k = 0; k < 12; k++)
				ts[k] = '0;
			// Part 0 walks rows, part 1 walks columns.
			for (part = 0; part < 2; part++) begin
				outer = part ? nc : nt;
				inner = part ? nt : nc;
				for (i = 0; i < outer; i++) begin
					for (p = 0; p < 4; p++)
						s[p] = '0;
					for (p = 0; p < 6; p++)
						dg[p] = '0;
					for (t = 0; t < inner; t++) begin
						addr = part ? t*MAXC + i : i*MAXC + t;
						doubled_kernel(matrix_copy[addr], k2, l2);
						x[0] = twop * k2 - ck;
						x[1] = twop * l2 - cl;
						x[2] = twop * k2 - c0;
						x[3] = twop * l2 - c0;
						for (p = 0; p < 4; p++)
							s[p] += x[p];
						for (p = 0; p < 6; p++)
							dg[p] += x[pair_lo[p]] * x[pair_hi[p]];
					end
					for (p = 0; p < 6; p++)
						ts[part*6+p] += s[pair_lo[p]] * s[pair_hi[p]] - dg[p];
				end
			end
			den = 192'(nt);
			den = den * nc * nt * nc * (nt - 1) * (nc - 1) * 16;
			for (k = 0; k < 6; k++) begin
				num = ts[k] * (nc * (nt - 1)) + ts[6+k] * (nt * (nc - 1));
				neg = num[127];
				mag = {64'd0, neg ? -num : num};
				mag = mag << 32;
				q = mag / den;
				r = mag % den;
				// Round half away from zero, then saturate.
				if (r >= den - r)
					q = q + 1;
				lim = neg ? (192'd1 << 63) : ((192'd1 << 63) - 1);
				if (q > lim)
					q = lim;
				vals[2+k] = neg ? -q[63:0] : q[63:0];
			end
		end
		for (k = 0; k < 8; k++) begin
			rs.stat_index = 3'(k);
			rs.stat_value = vals[k];
			rs.last = (k == 7);
			expected_stats.push_back(rs);
		end
	endtask

	// Update the predictor with one accepted item.
	task automatic accept_item(input item_t it);
		if (it.kind == KIND_LOAD)
			matrix_copy[int'(it.treat_index)*MAXC + int'(it.control_index)] = it.outcome;
		else
			predict_stats();
	endtask

	// Driver: bursts of items separated by random gaps.
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				accept_item(item);
			if (start && busy) begin
				// Hold the item until the block takes it.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					// Some bursts run straight into the next one.
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: results cannot be held off, so sample every strobe.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_strobe) begin
			if (expected_stats.size() == 0) begin
				report($sformatf("unexpected statistic index %0d", result.stat_index));
			end else begin
				want = expected_stats.pop_front();
				if (result.stat_index !== want.stat_index)
					report($sformatf("stat_index got %0d want %0d",
						result.stat_index, want.stat_index));
				if (result.stat_value !== want.stat_value)
					report($sformatf("stat %0d value got %h want %h",
						want.stat_index, result.stat_value, want.stat_value));
				if (result.last !== want.last)
					report($sformatf("stat %0d last got %b want %b",
						want.stat_index, result.last, want.last));
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COUNT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_TREAT_COUNT)
			treat_reg = val;
		else if (idx == REG_CONTROL_COUNT)
			control_reg = val;
		else
			split_reg = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [COUNT_W-1:0] tc, input logic [COUNT_W-1:0] cc,
			input logic st);
		write_reg(REG_TREAT_COUNT, tc);
		write_reg(REG_CONTROL_COUNT, cc);
		write_reg(REG_SPLIT_TIES, {6'd0, st});
	endtask

	// Wait until every item is taken and every statistic has come, then let the block settle.
	task automatic drain();
		@(posedge clk);
		while (pending_items.size() != 0 || start || expected_stats.size() != 0 || busy)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic push_load(input int ti, input int ci, input logic [1:0] oc);
		item_t it;
		it.kind = KIND_LOAD;
		it.treat_index = 6'(ti);
		it.control_index = 6'(ci);
		it.outcome = oc;
		cell_loaded[ti*MAXC+ci] = 1'b1;
		pending_items.push_back(it);
		random_count++;
	endtask

	// Fill any unloaded cell of the region in use, then ask for a compute.
	task automatic push_compute();
		int nt, nc, i, j;
		item_t it;
		nt = clamp_count(treat_reg, MAXT);
		nc = clamp_count(control_reg, MAXC);
		for (i = 0; i < nt; i++)
			for (j = 0; j < nc; j++)
				if (!cell_loaded[i*MAXC+j])
					push_load(i, j, 2'($urandom_range(0, 3)));
		it = '0;
		it.kind = KIND_COMPUTE;
		it.treat_index = 6'($urandom_range(0, 63));
		it.control_index = 6'($urandom_range(0, 63));
		it.outcome = 2'($urandom_range(0, 3));
		pending_items.push_back(it);
		random_count++;
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd1;
			default: return 7'($urandom_range(2, 6));
		endcase
	endfunction

	// Stimulus sequencer.
	initial begin
		int i, j, n, tc, cc;
		errors = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		treat_reg = 7'd1;
		control_reg = 7'd1;
		split_reg = 1'b0;
		random_count = 0;
		for (i = 0; i < MAXT*MAXC; i++) begin
			matrix_copy[i] = OUT_CTRL_WIN;
			cell_loaded[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset counts, a tie with and without splitting, count zero.
		push_load(0, 0, OUT_TIE);
		push_load(63, 63, OUT_TREAT_WIN);
		push_load(63, 0, OUT_NONE);
		push_load(0, 63, OUT_CTRL_WIN);
		push_compute();
		drain();
		set_config(7'd0, 7'd0, 1'b1);
		push_compute();
		drain();
		// Small matrix holding every code, both tie rules.
		set_config(7'd3, 7'd2, 1'b1);
		push_load(0, 0, OUT_CTRL_WIN);
		push_load(0, 1, OUT_TIE);
		push_load(1, 0, OUT_TREAT_WIN);
		push_load(1, 1, OUT_NONE);
		push_load(2, 0, OUT_TIE);
		push_load(2, 1, OUT_TREAT_WIN);
		push_compute();
		drain();
		write_reg(REG_SPLIT_TIES, 7'd0);
		push_compute();
		drain();
		// All treatment wins, then all control wins: the extremes of the win counts.
		set_config(7'd2, 7'd2, 1'b0);
		for (i = 0; i < 2; i++)
			for (j = 0; j < 2; j++)
				push_load(i, j, OUT_TREAT_WIN);
		push_compute();
		for (i = 0; i < 2; i++)
			for (j = 0; j < 2; j++)
				push_load(i, j, OUT_CTRL_WIN);
		push_compute();
		drain();
		random_count = 0;

		// Random phases: a setting, then loads mostly inside the region in use, with computes among them.
		while (random_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 11))
				0: begin
					tc = ($urandom_range(0, 1)) ? 64 : 127;
					cc = $urandom_range(1, 2);
				end
				1: begin
					tc = $urandom_range(1, 2);
					cc = ($urandom_range(0, 1)) ? 64 : 127;
				end
				default: begin
					tc = pick_count();
					cc = pick_count();
				end
			endcase
			set_config(7'(tc), 7'(cc), 1'($urandom_range(0, 1)));
			tc = clamp_count(treat_reg, MAXT);
			cc = clamp_count(control_reg, MAXC);
			n = $urandom_range(10, 40);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: push_load($urandom_range(0, 63), $urandom_range(0, 63),
						2'($urandom_range(0, 3)));
					1, 2: push_compute();
					default: push_load($urandom_range(0, tc - 1), $urandom_range(0, cc - 1),
						2'($urandom_range(0, 3)));
				endcase
			end
			push_compute();
			drain();
		end

		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
